[hdl/hdgl_pkg.sv]
// hdgl_pkg: shared constants and controller/datapath link types for the
// gamepad layout parser; no dependencies
package hdgl_pkg;

	localparam int USAGE_DEPTH_DEF = 16;
	localparam int AXIS_SLOTS_DEF  = 8;
	localparam int NUM_SLOTS       = 10;
	localparam int NUM_RESULTS     = 10;

	localparam logic [7:0]  LONG_PREFIX = 8'hFE;
	localparam logic [15:0] PAGE_BUTTON = 16'h0009;
	localparam logic [15:0] PAGE_DESK   = 16'h0001;
	localparam logic [31:0] USAGE_X     = 32'h0000_0030;
	localparam logic [31:0] USAGE_HAT   = 32'h0000_0039;
	localparam logic [31:0] BTN_LIMIT   = 32'd11;

	// item types
	localparam logic [1:0] TYPE_MAIN   = 2'd0;
	localparam logic [1:0] TYPE_GLOBAL = 2'd1;
	localparam logic [1:0] TYPE_LOCAL  = 2'd2;

	// tags
	localparam logic [3:0] TAG_INPUT  = 4'h8;
	localparam logic [3:0] TAG_PAGE   = 4'h0;
	localparam logic [3:0] TAG_LMIN   = 4'h1;
	localparam logic [3:0] TAG_LMAX   = 4'h2;
	localparam logic [3:0] TAG_RSIZE  = 4'h7;
	localparam logic [3:0] TAG_RID    = 4'h8;
	localparam logic [3:0] TAG_RCOUNT = 4'h9;
	localparam logic [3:0] TAG_USAGE  = 4'h0;
	localparam logic [3:0] TAG_UMIN   = 4'h1;
	localparam logic [3:0] TAG_UMAX   = 4'h2;

	typedef struct packed {
		logic       byte_take;
		logic       loop_rd;
		logic       loop_ev;
		logic       finish;
		logic       emit_load;
		logic       clear;
		logic [3:0] emit_idx;
	} hdgl_cmd_t;

	typedef struct packed {
		logic input_item;
		logic need_loop;
		logic loop_last;
	} hdgl_status_t;

endpackage

[hdl/hid_descriptor_gamepad_layout.sv]
// hid_descriptor_gamepad_layout: gamepad layout parser for hid report
// descriptors; top level joining hdgl_ctrl and hdgl_dp, uses hdgl_pkg
// a descriptor byte is taken while idle; a byte that ends an input item
// then walks n fields (at most USAGE_DEPTH+1), each a registered usage
// store read and then an evaluate step, followed by a finish step; the end
// marker gives ten result beats, held under back-pressure, then a clear step
// reset is asynchronous; after reset and after each end marker all parser
// state is cleared, no clearing pass is needed
module hid_descriptor_gamepad_layout #(
	parameter int USAGE_DEPTH = hdgl_pkg::USAGE_DEPTH_DEF,
	parameter int AXIS_SLOTS  = hdgl_pkg::AXIS_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel: one descriptor byte or the end marker per beat
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [7:0]         desc_byte,
	// result channel: one slot of the layout per beat
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         slot,
	output logic               present,
	output logic [15:0]        field_offset,
	output logic [7:0]         field_bits,
	output logic signed [31:0] range_low,
	output logic signed [31:0] range_high,
	output logic [7:0]         chosen_report,
	output logic               layout_ok,
	output logic               final_res
);
	import hdgl_pkg::*;

	hdgl_cmd_t    cmd;
	hdgl_status_t sts;

	// controller: accepts beats, walks fields, paces the result beats
	hdgl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: item splitter, descriptor state and the output register
	hdgl_dp #(
		.USAGE_DEPTH (USAGE_DEPTH),
		.AXIS_SLOTS  (AXIS_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.desc_byte     (desc_byte),
		.cmd           (cmd),
		.sts           (sts),
		.slot          (slot),
		.present       (present),
		.field_offset  (field_offset),
		.field_bits    (field_bits),
		.range_low     (range_low),
		.range_high    (range_high),
		.chosen_report (chosen_report),
		.layout_ok     (layout_ok),
		.final_res     (final_res)
	);

endmodule

[hdl/hdgl_ctrl.sv]
// hdgl_ctrl: sequencer for byte beats, the per-field usage walk and the
// ten result beats; uses hdgl_pkg
module hdgl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  hdgl_pkg::hdgl_status_t sts,
	output hdgl_pkg::hdgl_cmd_t    cmd
);
	import hdgl_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_LOOP_RD, S_LOOP_EV, S_FINISH, S_EMIT, S_CLEAR
	} state_t;

	state_t     state_q;
	logic [3:0] idx_q;
	logic       out_valid_q;
	logic       load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load      = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		cmd           = '0;
		cmd.byte_take = (state_q == S_IDLE) && in_valid && !kind;
		cmd.loop_rd   = (state_q == S_LOOP_RD);
		cmd.loop_ev   = (state_q == S_LOOP_EV);
		cmd.finish    = (state_q == S_FINISH);
		cmd.emit_load = load;
		cmd.clear     = (state_q == S_CLEAR);
		cmd.emit_idx  = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (kind) begin
							state_q <= S_EMIT;
							idx_q   <= '0;
						end else if (sts.input_item) begin
							state_q <= sts.need_loop ? S_LOOP_RD : S_FINISH;
						end
					end
				end
				S_LOOP_RD: state_q <= S_LOOP_EV;
				S_LOOP_EV: state_q <= sts.loop_last ? S_FINISH : S_LOOP_RD;
				S_FINISH:  state_q <= S_IDLE;
				S_EMIT: begin
					if (load) begin
						if (idx_q == 4'(NUM_RESULTS - 1))
							state_q <= S_CLEAR;
						else
							idx_q <= idx_q + 4'd1;
					end
				end
				S_CLEAR: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hdl/hdgl_dp.sv]
// hdgl_dp: item splitter, global/local state, usage store, slot table and
// result register; uses hdgl_pkg
module hdgl_dp #(
	parameter int USAGE_DEPTH = hdgl_pkg::USAGE_DEPTH_DEF,
	parameter int AXIS_SLOTS  = hdgl_pkg::AXIS_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             desc_byte,
	input  hdgl_pkg::hdgl_cmd_t    cmd,
	output hdgl_pkg::hdgl_status_t sts,
	output logic [3:0]             slot,
	output logic                   present,
	output logic [15:0]            field_offset,
	output logic [7:0]             field_bits,
	output logic signed [31:0]     range_low,
	output logic signed [31:0]     range_high,
	output logic [7:0]             chosen_report,
	output logic                   layout_ok,
	output logic                   final_res
);
	import hdgl_pkg::*;

	localparam int FW = $clog2(USAGE_DEPTH + 1);
	localparam int LW = $clog2(USAGE_DEPTH + 2);
	localparam int AW = (USAGE_DEPTH > 1) ? $clog2(USAGE_DEPTH) : 1;

	typedef enum logic [1:0] {PH_PREFIX, PH_LONGLEN, PH_LONGSKIP, PH_DATA} phase_t;

	phase_t       phase_q;
	logic [7:0]   prefix_q;
	logic [31:0]  accum_q;
	logic [8:0]   left_q;
	logic [15:0]  page_q;
	logic [31:0]  min_q, max_q, size_q, count_q;
	logic [7:0]   report_q;
	logic [31:0]  usage_mem [USAGE_DEPTH];
	logic [31:0]  usage_rd_q;
	logic [FW-1:0] fill_q;
	logic         range_q;
	logic [15:0]  offset_q;
	logic [7:0]   target_q;
	logic         fixed_q;
	logic [NUM_SLOTS-1:0] sp_q;
	logic [15:0]  soff_q  [NUM_SLOTS];
	logic [7:0]   sbits_q [NUM_SLOTS];
	logic [31:0]  slo_q   [NUM_SLOTS];
	logic [31:0]  shi_q   [NUM_SLOTS];
	logic [3:0]   btn_total_q;
	logic [15:0]  btn_start_q;
	logic [15:0]  prod_q;
	logic [LW-1:0] f_q, lim_q;
	logic [15:0]  facc_q;

	// item decode
	logic         exec_en;
	logic [7:0]   ex_prefix;
	logic [31:0]  ex_val, ex_signed;
	logic [3:0]   ex_tag;
	logic [1:0]   ex_type, ex_size;
	logic [2:0]   nbytes;
	logic [1:0]   k;
	logic [31:0]  merged;
	logic         collecting, btn_case;
	logic [31:0]  fill_p1;
	logic [LW-1:0] lim_d;
	logic [AW-1:0] rd_addr;
	logic         u_hit;
	logic [3:0]   u_slot;

	always_comb begin
		nbytes = (prefix_q[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix_q[1:0]};
		k      = 2'(3'(nbytes) - 3'(left_q));
		merged = accum_q | (32'(desc_byte) << {k, 3'b000});
		exec_en   = 1'b0;
		ex_prefix = desc_byte;
		ex_val    = '0;
		if (cmd.byte_take) begin
			if (phase_q == PH_PREFIX && desc_byte != LONG_PREFIX && desc_byte[1:0] == 2'd0)
				exec_en = 1'b1;
			else if (phase_q == PH_DATA && left_q == 9'd1) begin
				exec_en   = 1'b1;
				ex_prefix = prefix_q;
				ex_val    = merged;
			end
		end
		ex_tag  = ex_prefix[7:4];
		ex_type = ex_prefix[3:2];
		ex_size = ex_prefix[1:0];
		case (ex_size)
			2'd1:    ex_signed = {{24{ex_val[7]}}, ex_val[7:0]};
			2'd2:    ex_signed = {{16{ex_val[15]}}, ex_val[15:0]};
			2'd3:    ex_signed = ex_val;
			default: ex_signed = '0;
		endcase
		collecting = !fixed_q || (report_q == target_q);
		sts.input_item = exec_en && ex_type == TYPE_MAIN && ex_tag == TAG_INPUT;
		btn_case = sts.input_item && !ex_val[0] && collecting && page_q == PAGE_BUTTON;
		sts.need_loop = sts.input_item && !ex_val[0] && collecting && page_q == PAGE_DESK
			&& !range_q && fill_q != '0 && count_q != '0;
		fill_p1 = 32'(fill_q) + 32'd1;
		lim_d   = (count_q < fill_p1) ? count_q[LW-1:0] : fill_p1[LW-1:0];
		sts.loop_last = (f_q + LW'(1)) == lim_q;
		rd_addr = (32'(f_q) < 32'(fill_q)) ? f_q[AW-1:0] : AW'(32'(fill_q) - 32'd1);
		u_hit   = usage_rd_q >= USAGE_X && usage_rd_q <= USAGE_HAT;
		u_slot  = 4'(usage_rd_q - USAGE_X);
	end

	// usage store
	always_ff @(posedge clk) begin
		if (exec_en && ex_type == TYPE_LOCAL && ex_tag == TAG_USAGE
				&& 32'(fill_q) < 32'(USAGE_DEPTH))
			usage_mem[fill_q[AW-1:0]] <= ex_val;
		if (cmd.loop_rd)
			usage_rd_q <= usage_mem[rd_addr];
		prod_q <= 16'(size_q[15:0] * count_q[15:0]);
	end

	// slot payload, written once per slot
	always_ff @(posedge clk) begin
		if (cmd.loop_ev && u_hit && !sp_q[u_slot]) begin
			soff_q[u_slot]  <= facc_q;
			sbits_q[u_slot] <= size_q[7:0];
			slo_q[u_slot]   <= min_q;
			shi_q[u_slot]   <= max_q;
		end
		if (cmd.byte_take && sts.need_loop) begin
			lim_q  <= lim_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX; prefix_q <= '0; accum_q <= '0; left_q <= '0;
			page_q <= '0; min_q <= '0; max_q <= '0; size_q <= '0; count_q <= '0;
			report_q <= '0; fill_q <= '0; range_q <= 1'b0; offset_q <= '0;
			target_q <= '0; fixed_q <= 1'b0; sp_q <= '0;
			btn_total_q <= '0; btn_start_q <= '0; f_q <= '0; facc_q <= '0;
		end else if (cmd.clear) begin
			phase_q <= PH_PREFIX; prefix_q <= '0; accum_q <= '0; left_q <= '0;
			page_q <= '0; min_q <= '0; max_q <= '0; size_q <= '0; count_q <= '0;
			report_q <= '0; fill_q <= '0; range_q <= 1'b0; offset_q <= '0;
			target_q <= '0; fixed_q <= 1'b0; sp_q <= '0;
			btn_total_q <= '0; btn_start_q <= '0; f_q <= '0; facc_q <= '0;
		end else begin
			if (cmd.byte_take) begin
				unique case (phase_q)
					PH_PREFIX: begin
						if (desc_byte == LONG_PREFIX)
							phase_q <= PH_LONGLEN;
						else begin
							prefix_q <= desc_byte;
							accum_q  <= '0;
							if (desc_byte[1:0] != 2'd0) begin
								left_q  <= (desc_byte[1:0] == 2'd3) ? 9'd4
									: {7'd0, desc_byte[1:0]};
								phase_q <= PH_DATA;
							end
						end
					end
					PH_LONGLEN: begin
						left_q  <= 9'(desc_byte) + 9'd1;
						phase_q <= PH_LONGSKIP;
					end
					PH_LONGSKIP: begin
						left_q <= left_q - 9'd1;
						if (left_q == 9'd1)
							phase_q <= PH_PREFIX;
					end
					PH_DATA: begin
						accum_q <= merged;
						left_q  <= left_q - 9'd1;
						if (left_q == 9'd1)
							phase_q <= PH_PREFIX;
					end
					default: phase_q <= PH_PREFIX;
				endcase
			end

			if (exec_en) begin
				unique case (ex_type)
					TYPE_GLOBAL: begin
						case (ex_tag)
							TAG_PAGE:   page_q  <= ex_val[15:0];
							TAG_LMIN:   min_q   <= ex_signed;
							TAG_LMAX:   max_q   <= ex_signed;
							TAG_RSIZE:  size_q  <= ex_val;
							TAG_RCOUNT: count_q <= ex_val;
							TAG_RID: begin
								report_q <= ex_val[7:0];
								if (!fixed_q) begin
									target_q <= ex_val[7:0];
									offset_q <= '0;
								end else if (ex_val[7:0] != target_q)
									offset_q <= '0;
							end
							default: ;
						endcase
					end
					TYPE_LOCAL: begin
						if (ex_tag == TAG_USAGE) begin
							if (32'(fill_q) < 32'(USAGE_DEPTH))
								fill_q <= fill_q + FW'(1);
						end else if (ex_tag == TAG_UMIN || ex_tag == TAG_UMAX)
							range_q <= 1'b1;
					end
					TYPE_MAIN: begin
						// an input item clears the locals once its fields are walked
						if (ex_tag != TAG_INPUT) begin
							fill_q  <= '0;
							range_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end

			if (btn_case && btn_total_q == '0 && size_q == 32'd1) begin
				btn_start_q <= offset_q;
				btn_total_q <= (count_q > BTN_LIMIT) ? 4'(BTN_LIMIT) : count_q[3:0];
				if (!fixed_q) begin
					fixed_q  <= 1'b1;
					target_q <= report_q;
				end
			end

			if (cmd.byte_take && sts.need_loop) begin
				f_q    <= '0;
				facc_q <= offset_q;
			end

			if (cmd.loop_ev) begin
				f_q    <= f_q + LW'(1);
				facc_q <= facc_q + size_q[15:0];
				if (u_hit && !sp_q[u_slot]) begin
					sp_q[u_slot] <= 1'b1;
					if (!fixed_q) begin
						fixed_q  <= 1'b1;
						target_q <= report_q;
					end
				end
			end

			if (cmd.finish) begin
				offset_q <= offset_q + prod_q;
				fill_q   <= '0;
				range_q  <= 1'b0;
			end
		end
	end

	// slot mapping for the result beats
	logic [3:0] src [8];
	logic [7:0] ax_p;
	logic       rx_stick, ry_stick, ok;
	logic       r_p;
	logic [3:0] r_src;

	always_comb begin
		rx_stick = !sp_q[2] && sp_q[3];
		ry_stick = !sp_q[5] && sp_q[4];
		src[0] = 4'd0; ax_p[0] = sp_q[0];
		src[1] = 4'd1; ax_p[1] = sp_q[1];
		src[2] = sp_q[2] ? 4'd2 : 4'd3; ax_p[2] = sp_q[2] || sp_q[3];
		src[3] = sp_q[5] ? 4'd5 : 4'd4; ax_p[3] = sp_q[5] || sp_q[4];
		src[4] = 4'd3; ax_p[4] = sp_q[3] && !rx_stick;
		src[5] = 4'd4; ax_p[5] = sp_q[4] && !ry_stick;
		src[6] = 4'd6; ax_p[6] = sp_q[6];
		src[7] = 4'd7; ax_p[7] = sp_q[7];
		for (int a = 0; a < 8; a++)
			if (a >= AXIS_SLOTS)
				ax_p[a] = 1'b0;
		ok = |ax_p;
		if (cmd.emit_idx < 4'd8) begin
			r_p   = ax_p[cmd.emit_idx[2:0]];
			r_src = src[cmd.emit_idx[2:0]];
		end else begin
			r_p   = sp_q[9];
			r_src = 4'd9;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			slot          <= cmd.emit_idx;
			chosen_report <= target_q;
			layout_ok     <= ok;
			final_res     <= (cmd.emit_idx == 4'(NUM_RESULTS - 1));
			if (cmd.emit_idx == 4'(NUM_RESULTS - 1)) begin
				present      <= btn_total_q != '0;
				field_offset <= (btn_total_q != '0) ? btn_start_q : '0;
				field_bits   <= 8'(btn_total_q);
				range_low    <= '0;
				range_high   <= '0;
			end else begin
				present      <= r_p;
				field_offset <= r_p ? soff_q[r_src]  : '0;
				field_bits   <= r_p ? sbits_q[r_src] : '0;
				range_low    <= r_p ? slo_q[r_src]   : '0;
				range_high   <= r_p ? shi_q[r_src]   : '0;
			end
		end
	end

endmodule
